// ===== rtl/pmt_pkg.sv =====
package pmt_pkg;

  // Field widths
  localparam int unsigned CountW   = 32;
  localparam int unsigned MaxMatch = 4;
  localparam int unsigned ActW     = 3;
  localparam int unsigned CfgIdxW  = 3;

  // Request codes carried in req_type
  localparam logic [1:0] REQ_TICK     = 2'd0;
  localparam logic [1:0] REQ_FLAG_CLR = 2'd1;
  localparam logic [1:0] REQ_CTRL_WR  = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_PRESCALE = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_ACTIONS  = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MATCH0   = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_MATCH1   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_MATCH2   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_MATCH3   = 3'd5;

  // Bit positions inside one channel's action field
  localparam int unsigned ACT_IRQ   = 0;
  localparam int unsigned ACT_CLEAR = 1;
  localparam int unsigned ACT_STOP  = 2;

  // Bit positions of the control word
  localparam int unsigned CTRL_ENABLE = 0;
  localparam int unsigned CTRL_RESET  = 1;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [CountW-1:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [CountW-1:0]   timer_count;
    logic [CountW-1:0]   prescale_count;
    logic [MaxMatch-1:0] interrupt_flags;
    logic                counter_enabled;
    logic                counter_reset_held;
    logic                irq_raise;
  } out_item_t;

  typedef struct packed {
    logic [CountW-1:0]                 prescale_limit;
    logic [MaxMatch*ActW-1:0]          match_actions;
    logic [MaxMatch-1:0][CountW-1:0]   match_value;
  } cfg_t;

endpackage

// ===== rtl/pmt_cfg_regs.sv =====
module pmt_cfg_regs #(
  parameter int unsigned NUM_MATCH = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pmt_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [pmt_pkg::CountW-1:0]     cfg_wdata_i,
  output pmt_pkg::cfg_t                  cfg_o
);
  import pmt_pkg::*;

  logic [CountW-1:0]        prescale_q;
  logic [MaxMatch*ActW-1:0] actions_q;

  // Load prescaler and action fields
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prescale_q <= '0;
      actions_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PRESCALE: prescale_q <= cfg_wdata_i;
        CFG_ACTIONS:  actions_q  <= cfg_wdata_i[MaxMatch*ActW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o.prescale_limit = prescale_q;
  assign cfg_o.match_actions  = actions_q;

  // Compare values, one register per implemented channel
  for (genvar n = 0; n < MaxMatch; n++) begin : g_match
    if (n < NUM_MATCH) begin : g_impl
      logic [CountW-1:0] value_q;
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          value_q <= '0;
        end else if (cfg_we_i &&
                     cfg_index_i == CFG_MATCH0 + CfgIdxW'(n)) begin
          value_q <= cfg_wdata_i;
        end
      end
      assign cfg_o.match_value[n] = value_q;
    end else begin : g_absent
      assign cfg_o.match_value[n] = '0;
    end
  end

endmodule

// ===== rtl/pmt_timer.sv =====
module pmt_timer #(
  parameter int unsigned NUM_MATCH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  pmt_pkg::in_item_t   item_i,
  input  pmt_pkg::cfg_t       cfg_i,
  output pmt_pkg::out_item_t  result_o
);
  import pmt_pkg::*;

  logic [CountW-1:0]   count_q, count_d;
  logic [CountW-1:0]   pre_q, pre_d;
  logic [MaxMatch-1:0] flags_q, flags_d;
  logic                en_q, en_d;
  logic                hold_q, hold_d;
  logic                irq;

  logic [CountW-1:0]   count_inc;
  logic [MaxMatch-1:0] hit_irq, hit_clear, hit_stop;

  assign count_inc = count_q + CountW'(1);

  // Compare the stepped count against each active channel
  always_comb begin
    logic [ActW-1:0] act;
    hit_irq   = '0;
    hit_clear = '0;
    hit_stop  = '0;
    for (int n = 0; n < NUM_MATCH; n++) begin
      act = cfg_i.match_actions[ActW*n +: ActW];
      if (act != '0 && cfg_i.match_value[n] == count_inc) begin
        hit_irq[n]   = act[ACT_IRQ];
        hit_clear[n] = act[ACT_CLEAR];
        hit_stop[n]  = act[ACT_STOP];
      end
    end
  end

  // Next state for one item
  always_comb begin
    count_d = count_q;
    pre_d   = pre_q;
    flags_d = flags_q;
    en_d    = en_q;
    hold_d  = hold_q;
    irq     = 1'b0;
    case (item_i.req_type)
      REQ_TICK: begin
        if (en_q && !hold_q) begin
          if (pre_q < cfg_i.prescale_limit) begin
            pre_d = pre_q + CountW'(1);
          end else begin
            pre_d   = '0;
            count_d = (|hit_clear) ? '0 : count_inc;
            flags_d = flags_q | hit_irq;
            irq     = |hit_irq;
            if (|hit_stop) en_d = 1'b0;
          end
        end
      end
      REQ_FLAG_CLR: begin
        flags_d = flags_q & ~item_i.write_data[MaxMatch-1:0];
      end
      REQ_CTRL_WR: begin
        en_d   = item_i.write_data[CTRL_ENABLE];
        hold_d = item_i.write_data[CTRL_RESET];
        if (item_i.write_data[CTRL_RESET]) begin
          count_d = '0;
          pre_d   = '0;
        end
      end
      default: ;
    endcase
  end

  // Commit state when the item moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      pre_q   <= '0;
      flags_q <= '0;
      en_q    <= 1'b0;
      hold_q  <= 1'b0;
    end else if (step_i) begin
      count_q <= count_d;
      pre_q   <= pre_d;
      flags_q <= flags_d;
      en_q    <= en_d;
      hold_q  <= hold_d;
    end
  end

  // Result shows the state after the item
  assign result_o.timer_count        = count_d;
  assign result_o.prescale_count     = pre_d;
  assign result_o.interrupt_flags    = flags_d;
  assign result_o.counter_enabled    = en_d;
  assign result_o.counter_reset_held = hold_d;
  assign result_o.irq_raise          = irq;

endmodule

// ===== rtl/prescaled_match_timer_core.sv =====
// Channel | Signals                                   | Direction
// input   | in_valid_i, in_ready_o, in_data_i         | items in (tick, flag clear, control)
// output  | out_valid_o, out_ready_i, out_data_o      | one result item per input item
// config  | cfg_we_i, cfg_index_i, cfg_wdata_i        | register writes, no read-back
//
// One item per cycle sustained while the output is not stalled; an item's result
// shows on the output after the item passes the input register, then the result
// register, and can leave once out_ready_i is high.
// The timer state updates as an item moves from the input register into the
// result register: next-count compare against NUM_MATCH match values plus the
// prescale compare sets the path length.
// Reset clears all counters, flags, control bits and configuration registers.
// A stalled output holds its result; the input register keeps taking an item
// as long as the held item can move on in the same cycle.
module prescaled_match_timer_core #(
  parameter int unsigned NUM_MATCH = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  pmt_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output pmt_pkg::out_item_t            out_data_o,
  input  logic                          cfg_we_i,
  input  logic [pmt_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pmt_pkg::CountW-1:0]    cfg_wdata_i
);
  import pmt_pkg::*;

  cfg_t      cfg;
  in_item_t  in_q;
  logic      in_valid_q;
  out_item_t result;
  out_item_t out_q;
  logic      out_valid_q;
  logic      advance;

  pmt_cfg_regs #(
    .NUM_MATCH(NUM_MATCH)
  ) u_cfg (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .cfg_o(cfg)
  );

  // Move the held item on when the result register is free
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) in_q <= in_data_i;
  end

  pmt_timer #(
    .NUM_MATCH(NUM_MATCH)
  ) u_timer (
    .clk_i,
    .rst_ni,
    .step_i(advance),
    .item_i(in_q),
    .cfg_i(cfg),
    .result_o(result)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) out_q <= result;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/pmt_checker.sv =====
module pmt_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input pmt_pkg::out_item_t            out_data_o
);
  import pmt_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // An interrupt pulse leaves at least one flag pending
  a_irq_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.irq_raise |-> out_data_o.interrupt_flags != '0)
    else $error("irq without pending flag");

  // Counters stay zero while held in reset
  a_hold_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.counter_reset_held |->
      out_data_o.timer_count == '0 && out_data_o.prescale_count == '0)
    else $error("counters moved while held");

  // No interrupt while held in reset
  a_hold_irq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.irq_raise |-> !out_data_o.counter_reset_held)
    else $error("irq while held");

endmodule

bind prescaled_match_timer_core pmt_checker u_pmt_checker (.*);
